/* hw/rtl/pdf_pkg.sv */
// shared types and constants of the probe duplicate filter
`default_nettype none

package pdf_pkg;

  typedef enum logic [2:0] {
    VERDICT_NORMAL = 3'd0,
    VERDICT_TUNNEL = 3'd1,
    VERDICT_DUP    = 3'd2,
    VERDICT_MAGIC  = 3'd3,
    VERDICT_SHORT  = 3'd4,
    VERDICT_ENDED  = 3'd5
  } verdict_e;

  typedef enum logic {
    BK_IDLE,
    BK_SCAN
  } back_state_e;

  localparam logic [31:0] MAGIC_NORMAL = 32'h5052_4F42;
  localparam logic [31:0] MAGIC_TUNNEL = 32'h5052_4F57;
  localparam logic [10:0] MIN_LENGTH   = 11'd22;

  localparam int unsigned QUEUE_PTR_W = 1;
  localparam int unsigned QUEUE_DEPTH = 2 ** QUEUE_PTR_W;

  typedef struct packed {
    verdict_e    verdict;
    logic [31:0] seq;
    logic [47:0] mac;
    logic [63:0] latency;
  } probe_word_t;

  typedef struct packed {
    logic [47:0] mac;
    logic [31:0] seq;
  } src_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

/* hw/rtl/pdf_ram.sv */
// generic single-port-write ram with registered read
`default_nettype none

module pdf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                                          clk_i,
  input  wire logic                                          we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                              wdata_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                              rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* hw/rtl/pdf_front.sv */
// front end: takes a probe word, classifies it and works out its latency
`default_nettype none

module pdf_front
  import pdf_pkg::*;
(
  input  wire logic                start_i,
  input  wire logic [10:0]         packet_length_i,
  input  wire logic [31:0]         magic_word_i,
  input  wire logic [31:0]         sequence_number_i,
  input  wire logic signed [63:0]  send_time_us_i,
  input  wire logic [47:0]         source_mac_i,
  input  wire logic [62:0]         arrival_time_us_i,
  input  wire logic                session_ended_i,
  input  wire queue_status_t       status_i,
  output logic                     busy_o,
  output logic                     push_o,
  output probe_word_t              word_o
);

  verdict_e    verdict;
  logic [63:0] latency;

  always_comb begin
    if (session_ended_i) begin
      verdict = VERDICT_ENDED;
    end else if (packet_length_i < MIN_LENGTH) begin
      verdict = VERDICT_SHORT;
    end else if (magic_word_i == MAGIC_TUNNEL) begin
      verdict = VERDICT_TUNNEL;
    end else if (magic_word_i != MAGIC_NORMAL) begin
      verdict = VERDICT_MAGIC;
    end else begin
      verdict = VERDICT_NORMAL;
    end
  end

  // wrapping difference, arrival time is unsigned
  assign latency = {1'b0, arrival_time_us_i} - send_time_us_i;

  assign busy_o = status_i.full;
  assign push_o = start_i && !status_i.full;

  always_comb begin
    word_o.verdict = verdict;
    word_o.seq     = sequence_number_i;
    word_o.mac     = source_mac_i;
    word_o.latency = latency;
  end

endmodule

`default_nettype wire

/* hw/rtl/pdf_queue.sv */
// short queue of classified probe words between front and back
`default_nettype none

module pdf_queue
  import pdf_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire probe_word_t   word_i,
  input  wire logic          pop_i,
  output probe_word_t        word_o,
  output queue_status_t      status_o
);

  probe_word_t              slot_q [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QUEUE_PTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QUEUE_PTR_W:0]     count_q, count_d;
  logic                     do_push;
  logic                     do_pop;

  assign status_o.full  = (count_q == (QUEUE_PTR_W + 1)'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);

  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;

  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= word_i;
    end
  end

  assign word_o = slot_q[rd_ptr_q];

endmodule

`default_nettype wire

/* hw/rtl/pdf_back.sv */
// back end: source table scan, sequence check, counter and result register
`default_nettype none

module pdf_back
  import pdf_pkg::*;
#(
  parameter int unsigned MAX_SOURCES = 32
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire queue_status_t status_i,
  input  wire probe_word_t   head_i,
  output logic               pop_o,
  output logic               done_o,
  output logic [2:0]         verdict_o,
  output logic [63:0]        latency_o,
  output logic [31:0]        logged_total_o,
  output logic               table_full_o
);

  localparam int unsigned AW = (MAX_SOURCES > 1) ? $clog2(MAX_SOURCES) : 1;
  localparam int unsigned CW = $clog2(MAX_SOURCES + 1);

  back_state_e  state_q, state_d;
  probe_word_t  cur_q, cur_d;
  logic [AW-1:0] idx_q, idx_d;
  logic [CW-1:0] in_use_q, in_use_d;
  logic [31:0]  cnt_q, cnt_d;
  logic         done_q, done_d;
  verdict_e     verdict_q, verdict_d;
  logic [63:0]  lat_q, lat_d;
  logic         full_q, full_d;

  logic         ram_we;
  logic [AW-1:0] ram_waddr;
  src_entry_t   ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [$bits(src_entry_t)-1:0] ram_rdata;
  src_entry_t   rd_entry;

  logic [CW-1:0] idx_next;
  logic         hit;
  logic         dup;
  logic         more;
  logic         room;

  logic         fin;
  verdict_e     fin_verdict;
  logic [63:0]  fin_lat;
  logic         fin_full;
  logic         fin_logged;

  pdf_ram #(
    .WIDTH($bits(src_entry_t)),
    .DEPTH(MAX_SOURCES)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign rd_entry = src_entry_t'(ram_rdata);
  assign idx_next = CW'(idx_q) + CW'(1);
  assign hit      = (rd_entry.mac == cur_q.mac);
  assign dup      = (cur_q.seq <= rd_entry.seq);
  assign more     = (idx_next < in_use_q);
  assign room     = (in_use_q < CW'(MAX_SOURCES));

  // entry zero is read while idle so a scan can start at once
  assign ram_raddr = (state_q == BK_SCAN) ? idx_next[AW-1:0] : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!status_i.empty && head_i.verdict == VERDICT_NORMAL && in_use_q != '0) begin
          state_d = BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (hit || !more) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    cur_d       = cur_q;
    idx_d       = idx_q;
    in_use_d    = in_use_q;
    cnt_d       = cnt_q;
    done_d      = 1'b0;
    verdict_d   = verdict_q;
    lat_d       = lat_q;
    full_d      = full_q;
    pop_o       = 1'b0;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    fin         = 1'b0;
    fin_verdict = VERDICT_NORMAL;
    fin_lat     = cur_q.latency;
    fin_full    = 1'b0;
    fin_logged  = 1'b0;
    case (state_q)
      BK_IDLE: begin
        if (!status_i.empty) begin
          pop_o   = 1'b1;
          cur_d   = head_i;
          idx_d   = '0;
          fin_lat = head_i.latency;
          if (head_i.verdict != VERDICT_NORMAL) begin
            fin         = 1'b1;
            fin_verdict = head_i.verdict;
          end else if (in_use_q == '0) begin
            ram_we        = 1'b1;
            ram_waddr     = '0;
            ram_wdata.mac = head_i.mac;
            ram_wdata.seq = head_i.seq;
            in_use_d      = in_use_q + 1'b1;
            fin           = 1'b1;
          end
        end
      end
      BK_SCAN: begin
        if (hit) begin
          fin = 1'b1;
          if (dup) begin
            fin_verdict = VERDICT_DUP;
          end else begin
            ram_we        = 1'b1;
            ram_waddr     = idx_q;
            ram_wdata.mac = cur_q.mac;
            ram_wdata.seq = cur_q.seq;
          end
        end else if (more) begin
          idx_d = idx_next[AW-1:0];
        end else begin
          fin = 1'b1;
          if (room) begin
            ram_we        = 1'b1;
            ram_waddr     = in_use_q[AW-1:0];
            ram_wdata.mac = cur_q.mac;
            ram_wdata.seq = cur_q.seq;
            in_use_d      = in_use_q + 1'b1;
          end else begin
            fin_full = 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (fin) begin
      fin_logged = (fin_verdict == VERDICT_NORMAL) || (fin_verdict == VERDICT_TUNNEL);
      done_d     = 1'b1;
      verdict_d  = fin_verdict;
      full_d     = fin_full;
      lat_d      = fin_logged ? fin_lat : '0;
      if (fin_logged) begin
        cnt_d = cnt_q + 32'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= BK_IDLE;
      in_use_q <= '0;
      cnt_q    <= '0;
      done_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      in_use_q <= in_use_d;
      cnt_q    <= cnt_d;
      done_q   <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    idx_q     <= idx_d;
    verdict_q <= verdict_d;
    lat_q     <= lat_d;
    full_q    <= full_d;
  end

  assign done_o         = done_q;
  assign verdict_o      = verdict_q;
  assign latency_o      = lat_q;
  assign logged_total_o = cnt_q;
  assign table_full_o   = full_q;

`ifndef SYNTH
  a_in_use_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_use_q <= CW'(MAX_SOURCES))
    else $error("source count beyond table size");

  a_scan_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == BK_SCAN |-> CW'(idx_q) < in_use_q)
    else $error("scan index past sources in use");

  a_full_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && full_q |-> verdict_q == VERDICT_NORMAL && in_use_q == CW'(MAX_SOURCES))
    else $error("table full flagged with room left");

  a_dropped_no_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q && verdict_q != VERDICT_NORMAL && verdict_q != VERDICT_TUNNEL |-> lat_q == '0)
    else $error("dropped word carries latency");

  a_count_on_logged: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_d && (verdict_d == VERDICT_NORMAL || verdict_d == VERDICT_TUNNEL)
      |=> cnt_q == $past(cnt_q) + 32'd1)
    else $error("logged counter missed a logged word");
`endif

endmodule

`default_nettype wire

/* hw/rtl/probe_duplicate_filter_core.sv */
// top level of the probe duplicate filter
//
// One probe word is taken at a rising edge where start_i is high and busy_o
// is low. Each accepted word gives exactly one result word on verdict_o,
// transit_us_o, logged_total_o and table_full_o, shown for one cycle while
// done_o is high; results leave in the order the words came in.
// The front classifies the word and computes the latency in the accept
// cycle and writes it into a two-entry queue; the back pops it while idle.
// Tunnel, short, ended and bad-magic words, and normal words while the table
// is empty, finish as the back pops them, with no scan; the back takes one
// such word a cycle while no scan holds it. Other normal words scan the source
// table one entry a cycle through the table ram's registered read port,
// stopping at the entry that holds their source or after the last stored
// source. busy_o is high while the queue is full.
// Reset empties the queue, the table (no sources in use) and the logged
// counter; no result is pending after it. The receiver cannot stall.
`default_nettype none

module probe_duplicate_filter_core
  import pdf_pkg::*;
#(
  parameter int unsigned MAX_SOURCES = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  output logic                     busy_o,
  input  wire logic [10:0]         packet_length_i,
  input  wire logic [31:0]         magic_word_i,
  input  wire logic [31:0]         sequence_number_i,
  input  wire logic signed [63:0]  send_time_us_i,
  input  wire logic [47:0]         source_mac_i,
  input  wire logic [62:0]         arrival_time_us_i,
  input  wire logic                session_ended_i,
  output logic                     done_o,
  output logic [2:0]               verdict_o,
  output logic signed [63:0]       transit_us_o,
  output logic [31:0]              logged_total_o,
  output logic                     table_full_o
);

  queue_status_t status;
  probe_word_t   push_word;
  probe_word_t   head_word;
  logic          push;
  logic          pop;
  logic [63:0]   latency;

  pdf_front u_front (
    .start_i           (start_i),
    .packet_length_i   (packet_length_i),
    .magic_word_i      (magic_word_i),
    .sequence_number_i (sequence_number_i),
    .send_time_us_i    (send_time_us_i),
    .source_mac_i      (source_mac_i),
    .arrival_time_us_i (arrival_time_us_i),
    .session_ended_i   (session_ended_i),
    .status_i          (status),
    .busy_o            (busy_o),
    .push_o            (push),
    .word_o            (push_word)
  );

  pdf_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .word_i   (push_word),
    .pop_i    (pop),
    .word_o   (head_word),
    .status_o (status)
  );

  pdf_back #(
    .MAX_SOURCES(MAX_SOURCES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .status_i       (status),
    .head_i         (head_word),
    .pop_o          (pop),
    .done_o         (done_o),
    .verdict_o      (verdict_o),
    .latency_o      (latency),
    .logged_total_o (logged_total_o),
    .table_full_o   (table_full_o)
  );

  assign transit_us_o = $signed(latency);

endmodule

`default_nettype wire

/* dv/probe_duplicate_filter_checker.sv */
// checker for the probe duplicate filter: predicts each result word and compares it
module probe_duplicate_filter_checker
  import pdf_pkg::*;
#(
  parameter int unsigned MAX_SOURCES = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               start_i,
  input  wire logic               busy_i,
  input  wire logic [10:0]        packet_length_i,
  input  wire logic [31:0]        magic_word_i,
  input  wire logic [31:0]        sequence_number_i,
  input  wire logic signed [63:0] send_time_us_i,
  input  wire logic [47:0]        source_mac_i,
  input  wire logic [62:0]        arrival_time_us_i,
  input  wire logic               session_ended_i,
  input  wire logic               done_i,
  input  wire logic [2:0]         verdict_i,
  input  wire logic signed [63:0] transit_us_i,
  input  wire logic [31:0]        logged_total_i,
  input  wire logic               table_full_i,
  output logic [31:0]             error_count_o,
  output logic [31:0]             pending_o
);

  typedef struct packed {
    verdict_e    verdict;
    logic [63:0] latency;
    logic [31:0] total;
    logic        full;
  } probe_result_t;

  logic [47:0]   known_mac [MAX_SOURCES];
  logic [31:0]   known_seq [MAX_SOURCES];
  int unsigned   sources_used;
  logic [31:0]   logged_count;
  probe_result_t pending_verdicts [$];
  int unsigned   mismatches = 0;

  assign error_count_o = mismatches;
  assign pending_o     = pending_verdicts.size();

  task automatic classify_probe();
    probe_result_t r;
    bit            found;
    int unsigned   i;
    r.verdict = VERDICT_NORMAL;
    r.latency = '0;
    r.full    = 1'b0;
    found     = 1'b0;
    if (session_ended_i) begin
      r.verdict = VERDICT_ENDED;
    end else if (packet_length_i < MIN_LENGTH) begin
      r.verdict = VERDICT_SHORT;
    end else if (magic_word_i == MAGIC_TUNNEL) begin
      r.verdict = VERDICT_TUNNEL;
    end else if (magic_word_i != MAGIC_NORMAL) begin
      r.verdict = VERDICT_MAGIC;
    end else begin
      for (i = 0; i < sources_used && !found; i++) begin
        if (known_mac[i] == source_mac_i) begin
          found = 1'b1;
          if (sequence_number_i <= known_seq[i]) r.verdict = VERDICT_DUP;
          else known_seq[i] = sequence_number_i;
        end
      end
      if (!found) begin
        if (sources_used < MAX_SOURCES) begin
          known_mac[sources_used] = source_mac_i;
          known_seq[sources_used] = sequence_number_i;
          sources_used++;
        end else begin
          r.full = 1'b1;
        end
      end
    end
    if (r.verdict == VERDICT_NORMAL || r.verdict == VERDICT_TUNNEL) begin
      logged_count++;
      r.latency = {1'b0, arrival_time_us_i} - send_time_us_i;
    end
    r.total = logged_count;
    pending_verdicts.push_back(r);
  endtask

  task automatic compare_result();
    probe_result_t want;
    want = pending_verdicts.pop_front();
    if (verdict_i !== want.verdict) begin
      mismatches++;
      $error("verdict: expected %0d, actual %0d", want.verdict, verdict_i);
    end
    if (transit_us_i !== want.latency) begin
      mismatches++;
      $error("transit_us: expected %0h, actual %0h", want.latency, transit_us_i);
    end
    if (logged_total_i !== want.total) begin
      mismatches++;
      $error("logged_total: expected %0d, actual %0d", want.total, logged_total_i);
    end
    if (table_full_i !== want.full) begin
      mismatches++;
      $error("table_full: expected %0b, actual %0b", want.full, table_full_i);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sources_used = 0;
      logged_count = '0;
      pending_verdicts.delete();
    end else begin
      if (done_i) begin
        if (pending_verdicts.size() == 0) begin
          mismatches++;
          $error("result word with no probe pending");
        end else begin
          compare_result();
        end
      end
      if (start_i && !busy_i) classify_probe();
    end
  end

endmodule

/* dv/tb_probe_duplicate_filter_core.sv */
// testbench top of the probe duplicate filter: stimulus, watchdog and verdict
module tb_probe_duplicate_filter_core;
  import pdf_pkg::*;

  localparam int unsigned PROBE_COUNT  = 900;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned POOL_SIZE    = 48;

  typedef struct {
    logic [10:0] len;
    logic [31:0] magic;
    logic [31:0] seq;
    logic [63:0] sent;
    logic [47:0] mac;
    logic [62:0] arrival;
    logic        ended;
  } probe_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start_i;
  logic               busy_o;
  logic [10:0]        packet_length_i;
  logic [31:0]        magic_word_i;
  logic [31:0]        sequence_number_i;
  logic signed [63:0] send_time_us_i;
  logic [47:0]        source_mac_i;
  logic [62:0]        arrival_time_us_i;
  logic               session_ended_i;
  logic               done_o;
  logic [2:0]         verdict_o;
  logic signed [63:0] transit_us_o;
  logic [31:0]        logged_total_o;
  logic               table_full_o;
  logic [31:0]        error_count;
  logic [31:0]        pending_count;

  logic [47:0] mac_pool [POOL_SIZE];
  logic [31:0] seq_pool [POOL_SIZE];
  bit          idle_en = 1'b1;
  int unsigned stall_cycles = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  probe_duplicate_filter_core dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .packet_length_i   (packet_length_i),
    .magic_word_i      (magic_word_i),
    .sequence_number_i (sequence_number_i),
    .send_time_us_i    (send_time_us_i),
    .source_mac_i      (source_mac_i),
    .arrival_time_us_i (arrival_time_us_i),
    .session_ended_i   (session_ended_i),
    .done_o            (done_o),
    .verdict_o         (verdict_o),
    .transit_us_o      (transit_us_o),
    .logged_total_o    (logged_total_o),
    .table_full_o      (table_full_o)
  );

  probe_duplicate_filter_checker u_checker (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_i            (busy_o),
    .packet_length_i   (packet_length_i),
    .magic_word_i      (magic_word_i),
    .sequence_number_i (sequence_number_i),
    .send_time_us_i    (send_time_us_i),
    .source_mac_i      (source_mac_i),
    .arrival_time_us_i (arrival_time_us_i),
    .session_ended_i   (session_ended_i),
    .done_i            (done_o),
    .verdict_i         (verdict_o),
    .transit_us_i      (transit_us_o),
    .logged_total_i    (logged_total_o),
    .table_full_i      (table_full_o),
    .error_count_o     (error_count),
    .pending_o         (pending_count)
  );

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  function automatic probe_t normal_probe(logic [47:0] mac, logic [31:0] seq);
    probe_t      p;
    logic [63:0] t;
    t         = rand64();
    p.len     = 11'($urandom_range(2047, 22));
    p.magic   = MAGIC_NORMAL;
    p.seq     = seq;
    p.sent    = rand64();
    p.mac     = mac;
    p.arrival = t[62:0];
    p.ended   = 1'b0;
    return p;
  endfunction

  // called at a falling edge, returns at the falling edge after the word is taken
  task automatic send_probe(input probe_t p);
    while (idle_en && $urandom_range(99) < 17) begin
      start_i      = 1'b0;
      magic_word_i = $urandom();
      @(negedge clk_i);
    end
    packet_length_i   = p.len;
    magic_word_i      = p.magic;
    sequence_number_i = p.seq;
    send_time_us_i    = p.sent;
    source_mac_i      = p.mac;
    arrival_time_us_i = p.arrival;
    session_ended_i   = p.ended;
    start_i           = 1'b1;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni || (start_i && !busy_o) || done_o) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("tb_probe_duplicate_filter_core failed");
        $finish;
      end
    end
  end

  initial begin
    probe_t      p;
    int unsigned n;
    int unsigned cap;
    int unsigned idx;
    int unsigned pick;
    int unsigned kind;
    logic [31:0] seq;
    logic [47:0] mac;
    logic [63:0] wide;

    rst_ni            = 1'b0;
    start_i           = 1'b0;
    packet_length_i   = '0;
    magic_word_i      = '0;
    sequence_number_i = '0;
    send_time_us_i    = '0;
    source_mac_i      = '0;
    arrival_time_us_i = '0;
    session_ended_i   = 1'b0;

    mac_pool[0] = '0;
    mac_pool[1] = '1;
    seq_pool[0] = 32'd5;
    seq_pool[1] = '1;
    for (n = 2; n < POOL_SIZE; n++) begin
      wide        = rand64();
      mac_pool[n] = wide[47:0];
      seq_pool[n] = $urandom();
    end

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed words
    p = normal_probe('0, '0);
    p.ended = 1'b1;
    send_probe(p);
    p = normal_probe('0, '0);
    p.len = '0;
    send_probe(p);
    p.len = 11'd21;
    send_probe(p);
    p.len = 11'd22;
    send_probe(p);
    send_probe(normal_probe('0, '0));
    send_probe(normal_probe('0, 32'd1));
    send_probe(normal_probe('0, 32'd1));
    p = normal_probe('1, '1);
    p.len     = '1;
    p.sent    = 64'h8000_0000_0000_0000;
    p.arrival = '1;
    send_probe(p);
    send_probe(normal_probe('1, '1));
    send_probe(normal_probe('1, '0));
    p = normal_probe('0, '0);
    p.magic = MAGIC_TUNNEL;
    send_probe(p);
    p.magic = '0;
    send_probe(p);
    p.magic = '1;
    send_probe(p);
    p.magic = MAGIC_NORMAL ^ 32'h1;
    send_probe(p);
    p.magic = MAGIC_TUNNEL ^ 32'h8000_0000;
    send_probe(p);
    p = normal_probe('0, 32'd5);
    p.ended = 1'b1;
    p.len   = '0;
    p.magic = '0;
    send_probe(p);
    p.ended = 1'b0;
    send_probe(p);
    p = normal_probe('0, 32'd5);
    p.sent    = 64'h7FFF_FFFF_FFFF_FFFF;
    p.arrival = '0;
    send_probe(p);

    // random words over a slowly widening set of sources
    for (n = 0; n < PROBE_COUNT; n++) begin
      cap = 4 + n / 15;
      if (cap > POOL_SIZE - 1) cap = POOL_SIZE - 1;
      idx = $urandom_range(cap, 0);
      idle_en = (n < 300 || n >= 450);
      if (n == 500) begin
        start_i = 1'b0;
        wait (pending_count == 0);
        @(negedge clk_i);
      end
      pick = $urandom_range(99);
      if (pick < 70) begin
        seq = seq_pool[idx] + $urandom_range(3, 1);
        seq_pool[idx] = seq;
      end else if (pick < 85) begin
        seq = seq_pool[idx] - $urandom_range(2, 0);
      end else begin
        seq = $urandom();
      end
      mac = mac_pool[idx];
      if ($urandom_range(99) < 5) begin
        wide = rand64();
        mac  = wide[47:0];
      end
      p = normal_probe(mac, seq);
      kind = $urandom_range(99);
      if (kind < 4) begin
        p.ended = 1'b1;
      end else if (kind < 9) begin
        p.len = 11'($urandom_range(21, 0));
      end else if (kind < 19) begin
        p.magic = MAGIC_TUNNEL;
      end else if (kind < 26) begin
        if (kind[0]) p.magic = $urandom();
        else p.magic = MAGIC_NORMAL ^ (32'h1 << $urandom_range(31, 0));
      end
      send_probe(p);
    end

    start_i = 1'b0;
    wait (pending_count == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("tb_probe_duplicate_filter_core passed");
    end else begin
      $display("tb_probe_duplicate_filter_core failed");
    end
    $finish;
  end

endmodule
